// ===== hdl/ascii_command_decoder_core_defines.svh =====
// assertion macros for the ascii command decoder checker
// uses clk and arst_n from the scope of the module that expands them
`ifndef ASCII_COMMAND_DECODER_CORE_DEFINES_SVH
`define ASCII_COMMAND_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ACD_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acd check failed");

// next-cycle implication, disabled during reset
`define ACD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acd check failed");

`endif

// ===== hdl/acd_pkg.sv =====
// shared types and constants for the ascii command decoder
// no dependencies
package acd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SEMI  = 8'h3B;
	localparam logic [7:0] CHAR_QUOTE = 8'h27;
	localparam logic [7:0] CHAR_0     = 8'h30;
	localparam logic [7:0] CHAR_9     = 8'h39;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_LA    = 8'h61;
	localparam logic [7:0] CHAR_LZ    = 8'h7A;

	localparam logic [0:0]  CFG_DEST_CAPACITY = 1'b0;
	localparam logic [0:0]  CFG_ESCAPE_CHAR   = 1'b1;
	localparam logic [15:0] CAPACITY_RESET    = 16'd256;
	localparam logic [7:0]  ESCAPE_RESET      = 8'd94;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_HEX  = 2'd1,
		ST_NO_SPACE = 2'd2
	} status_t;

	// one queue entry: a summary, or one or two data bytes
	typedef struct packed {
		logic        two;
		logic [7:0]  byte0;
		logic [7:0]  byte1;
		logic        summary;
		status_t     status;
		logic [15:0] length;
	} acd_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} acd_queue_status_t;

endpackage

// ===== hdl/acd_front.sv =====
// front end: accepts characters, tracks command state, builds queue entries
// depends on acd_pkg
module acd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [7:0]         in_char,
	output logic               in_stall,
	input  logic [15:0]        cap,
	input  logic [7:0]         esc_char,
	input  acd_pkg::acd_queue_status_t q_stat,
	output logic               push,
	output acd_pkg::acd_entry_t entry
);
	import acd_pkg::*;

	logic        in_quote_q, quote_pend_q, hex_pend_q, high_inv_q;
	logic [3:0]  high_nib_q;
	logic [15:0] count_q;
	status_t     abort_q;

	logic        iq, qp, hp, hi;
	logic [3:0]  hn;
	logic [15:0] cnt;
	status_t     ab;
	logic        accept, term, emit, esc, lower;
	logic [7:0]  b;
	logic [4:0]  hx;
	logic [16:0] cnt_p1, cnt_p2, cap_x;

	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] v;
		v = 8'd0;
		if (c >= CHAR_0 && c <= CHAR_9) begin
			v = c - CHAR_0;
			return {1'b0, v[3:0]};
		end else if (c >= CHAR_A && c <= CHAR_F) begin
			v = c - CHAR_A + 8'd10;
			return {1'b0, v[3:0]};
		end
		return 5'b10000;
	endfunction

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign term     = (in_char == CHAR_NUL) || (in_char == CHAR_SEMI);
	assign lower    = (in_char >= CHAR_LA) && (in_char <= CHAR_LZ);
	assign hx       = hex_digit(in_char);
	assign cnt_p1   = {1'b0, count_q} + 17'd1;
	assign cnt_p2   = {1'b0, count_q} + 17'd2;
	assign cap_x    = {1'b0, cap};

	always_comb begin
		iq    = in_quote_q;
		qp    = quote_pend_q;
		hp    = hex_pend_q;
		hn    = high_nib_q;
		hi    = high_inv_q;
		cnt   = count_q;
		ab    = abort_q;
		emit  = 1'b0;
		esc   = 1'b0;
		b     = 8'd0;
		push  = 1'b0;
		entry = '0;
		if (accept) begin
			if (term) begin
				push          = 1'b1;
				entry.summary = 1'b1;
				entry.status  = (cap == 16'd0) ? ST_NO_SPACE : abort_q;
				entry.length  = (entry.status == ST_OK) ? count_q : 16'd0;
				iq  = 1'b0;
				qp  = 1'b0;
				hp  = 1'b0;
				hn  = 4'd0;
				hi  = 1'b0;
				cnt = 16'd0;
				ab  = ST_OK;
			end else if (abort_q != ST_OK) begin
				ab = abort_q;
			end else if (cap == 16'd0) begin
				ab = ST_NO_SPACE;
			end else begin
				if (qp && in_char != CHAR_QUOTE) begin
					iq = 1'b0;
					qp = 1'b0;
				end
				if (hp) begin
					hp = 1'b0;
					if (hx[4] || hi) begin
						ab = ST_BAD_HEX;
					end else begin
						b    = {hn, hx[3:0]};
						emit = 1'b1;
					end
				end else if (iq) begin
					if (in_char == CHAR_QUOTE && !qp) begin
						qp = 1'b1;
					end else begin
						qp   = 1'b0;
						b    = in_char;
						emit = 1'b1;
					end
				end else if (in_char >= CHAR_0 && in_char <= CHAR_F) begin
					hn = hx[3:0];
					hi = hx[4];
					hp = 1'b1;
				end else if (in_char == CHAR_QUOTE) begin
					iq = 1'b1;
				end else if (lower && esc_char != 8'd0) begin
					esc  = 1'b1;
					b    = in_char;
					emit = 1'b1;
				end
				if (emit) begin
					if (esc_char != 8'd0 && b == esc_char) begin
						esc = 1'b1;
					end
					if ({1'b0, count_q} >= cap_x) begin
						ab = ST_NO_SPACE;
					end else if (esc) begin
						push        = 1'b1;
						entry.byte0 = esc_char;
						if (cnt_p1 >= cap_x) begin
							ab  = ST_NO_SPACE;
							cnt = cnt_p1[15:0];
						end else begin
							entry.two   = 1'b1;
							entry.byte1 = b;
							cnt         = cnt_p2[15:0];
							if (cnt_p2 >= cap_x) begin
								ab = ST_NO_SPACE;
							end
						end
					end else begin
						push        = 1'b1;
						entry.byte0 = b;
						cnt         = cnt_p1[15:0];
						if (cnt_p1 >= cap_x) begin
							ab = ST_NO_SPACE;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_quote_q   <= 1'b0;
			quote_pend_q <= 1'b0;
			hex_pend_q   <= 1'b0;
			high_nib_q   <= 4'd0;
			high_inv_q   <= 1'b0;
			count_q      <= 16'd0;
			abort_q      <= ST_OK;
		end else begin
			in_quote_q   <= iq;
			quote_pend_q <= qp;
			hex_pend_q   <= hp;
			high_nib_q   <= hn;
			high_inv_q   <= hi;
			count_q      <= cnt;
			abort_q      <= ab;
		end
	end

endmodule

// ===== hdl/acd_queue.sv =====
// small fifo of decoded entries between front and back end
// depends on acd_pkg
module acd_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  acd_pkg::acd_entry_t       wr_entry,
	input  logic                      pop,
	output acd_pkg::acd_entry_t       rd_entry,
	output acd_pkg::acd_queue_status_t stat
);
	import acd_pkg::*;

	acd_entry_t          mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;
	logic                do_push, do_pop;

	assign stat.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_entry   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hdl/acd_back.sv =====
// back end: turns queue entries into output transfers, one per cycle while out_stall is low
// depends on acd_pkg
module acd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  acd_pkg::acd_entry_t        rd_entry,
	input  acd_pkg::acd_queue_status_t q_stat,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [7:0]                 out_byte,
	output logic                       is_summary,
	output logic [1:0]                 status,
	output logic [15:0]                length,
	output logic                       last
);
	import acd_pkg::*;

	logic        valid_q, pend_q, load;
	logic [7:0]  second_q;
	logic [7:0]  byte_q;
	logic        summary_q, last_q;
	status_t     status_q;
	logic [15:0] length_q;

	assign load = !valid_q || !out_stall;
	assign pop  = load && !pend_q && !q_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else if (load) begin
			if (pend_q) begin
				valid_q <= 1'b1;
				pend_q  <= 1'b0;
			end else if (!q_stat.empty) begin
				valid_q <= 1'b1;
				pend_q  <= rd_entry.two;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_q) begin
				byte_q    <= second_q;
				summary_q <= 1'b0;
				status_q  <= ST_OK;
				length_q  <= 16'd0;
				last_q    <= 1'b1;
			end else if (!q_stat.empty) begin
				byte_q    <= rd_entry.byte0;
				second_q  <= rd_entry.byte1;
				summary_q <= rd_entry.summary;
				status_q  <= rd_entry.status;
				length_q  <= rd_entry.length;
				last_q    <= !rd_entry.two;
			end
		end
	end

	assign out_valid  = valid_q;
	assign out_byte   = byte_q;
	assign is_summary = summary_q;
	assign status     = status_q;
	assign length     = length_q;
	assign last       = last_q;

endmodule

// ===== hdl/ascii_command_decoder_core.sv =====
// ascii command decoder top level: config registers, front end, queue, back end
// a result passes through the queue and then the back-end output register after its character transfer
// throughput: one character per cycle while the queue is not full; an escaped byte takes two output transfers,
// so a long run of escaped bytes fills the four-entry queue, after which in_stall holds back characters
// reset: command state cleared, dest_capacity 256, escape_char 94, queue empty
module ascii_command_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_summary,
	output logic [1:0]  status,
	output logic [15:0] length,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import acd_pkg::*;

	logic [15:0]       cap_q;
	logic [7:0]        esc_q;
	logic              push, pop;
	acd_entry_t        wr_entry, rd_entry;
	acd_queue_status_t q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
			esc_q <= ESCAPE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_DEST_CAPACITY: cap_q <= cfg_data;
				CFG_ESCAPE_CHAR:   esc_q <= cfg_data[7:0];
				default:           cap_q <= cap_q;
			endcase
		end
	end

	acd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_char  (in_char),
		.in_stall (in_stall),
		.cap      (cap_q),
		.esc_char (esc_q),
		.q_stat   (q_stat),
		.push     (push),
		.entry    (wr_entry)
	);

	acd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (rd_entry),
		.stat     (q_stat)
	);

	acd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_entry   (rd_entry),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.is_summary (is_summary),
		.status     (status),
		.length     (length),
		.last       (last)
	);

endmodule

// ===== hdl/acd_checker.sv =====
// port-level checks for the ascii command decoder, bound to the top level
// depends on ascii_command_decoder_core_defines.svh
`include "ascii_command_decoder_core_defines.svh"

module acd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        is_summary,
	input logic [1:0]  status,
	input logic [15:0] length,
	input logic        last
);

	`ACD_ASSERT_IMPLY(a_summary_form, out_valid && is_summary, out_byte == 8'd0 && last)
	`ACD_ASSERT_IMPLY(a_data_form, out_valid && !is_summary, status == 2'd0 && length == 16'd0)
	`ACD_ASSERT_IMPLY(a_status_code, out_valid && is_summary, status != 2'd3)
	`ACD_ASSERT_IMPLY(a_abort_length, out_valid && status != 2'd0, length == 16'd0)
	`ACD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_byte))

endmodule

bind ascii_command_decoder_core acd_checker u_acd_checker (.*);
